[src/sjfs_pkg.sv]
// Shared types and constants for the shortest-job-first sorter.
package sjfs_pkg;

  localparam int unsigned TAG_BITS = 8;
  localparam int unsigned LEN_BITS = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Per-cycle command broadcast from the controller to every cell.
  typedef struct packed {
    logic ins;    // place the new job, shift larger entries up
    logic drain;  // shift every entry down by one
  } sjfs_ctrl_t;

endpackage

[src/sjfs_cell.sv]
// One compare-and-shift cell of the sorted job chain.
module sjfs_cell #(
  parameter int unsigned KEY_BITS = 8
) (
  input  logic                          clk,
  input  sjfs_pkg::sjfs_ctrl_t          ctrl,
  input  logic [KEY_BITS-1:0]           new_key,
  input  logic [sjfs_pkg::TAG_BITS-1:0] new_tag,
  input  logic                          occ,
  input  logic                          prev_occ,
  input  logic                          prev_gt,
  input  logic [KEY_BITS-1:0]           prev_key,
  input  logic [sjfs_pkg::TAG_BITS-1:0] prev_tag,
  input  logic [KEY_BITS-1:0]           next_key,
  input  logic [sjfs_pkg::TAG_BITS-1:0] next_tag,
  output logic                          gt,
  output logic [KEY_BITS-1:0]           key,
  output logic [sjfs_pkg::TAG_BITS-1:0] tag
);
  import sjfs_pkg::*;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                place;

  // Strictly greater keeps equal keys in arrival order.
  assign gt    = occ && (key_r > new_key);
  assign place = !prev_gt && prev_occ && (gt || !occ);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctrl.ins) begin
      if (prev_gt) begin
        key_nxt = prev_key;
        tag_nxt = prev_tag;
      end else if (place) begin
        key_nxt = new_key;
        tag_nxt = new_tag;
      end
    end else if (ctrl.drain) begin
      key_nxt = next_key;
      tag_nxt = next_tag;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign key = key_r;
  assign tag = tag_r;

endmodule

[src/shortest_job_first_sorter_unit.sv]
// Top level of the shortest-job-first sorter: cell chain plus drain control.
//
// Jobs (length, tag) are kept in a chain of DEPTH cells sorted by ascending
// length; a job equal to stored ones lands behind them, so ties leave in
// arrival order. An insert item produces no result, so inserts are
// accepted back to back. A flush item drains the chain through cell 0, one
// result per cycle while the output is not stalled, marks the final result
// with out_last, then clears the store and the sticky overflow flag; a
// flush of an empty store gives a single result with out_empty_res set. A
// flush keeps in_stall high until its final result is loaded, as the chain
// shifts one entry toward cell 0 per result. An insert into a full store is
// dropped and sets the overflow flag, reported on every result of the next
// flush. Only the low KEY_BITS bits of in_job_length take part in the
// ordering.
module shortest_job_first_sorter_unit #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [sjfs_pkg::LEN_BITS-1:0] in_job_length,
  input  logic [sjfs_pkg::TAG_BITS-1:0] in_job_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sjfs_pkg::TAG_BITS-1:0] out_tag,
  output logic [sjfs_pkg::LEN_BITS-1:0] out_length,
  output logic                          out_last,
  output logic                          out_empty_res,
  output logic                          out_overflowed
);
  import sjfs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Control state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             busy_r, busy_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Output payload
  logic [TAG_BITS-1:0] out_tag_r, out_tag_nxt;
  logic [LEN_BITS-1:0] out_length_r, out_length_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_empty_r, out_empty_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  // Chain wiring
  logic [KEY_BITS-1:0] key_w [DEPTH];
  logic [TAG_BITS-1:0] tag_w [DEPTH];
  logic                gt_w  [DEPTH];
  logic                occ_w [DEPTH];

  logic [KEY_BITS-1:0] new_key;
  logic                in_acc;
  logic                full;
  logic                fire;
  logic                final_item;
  sjfs_ctrl_t          ctrl;

  assign new_key    = KEY_BITS'(in_job_length);
  assign in_stall   = busy_r;
  assign in_acc     = in_valid && !in_stall;
  assign full       = (count_r == CNT_W'(DEPTH));
  // The output register frees up this cycle when empty or being taken.
  assign fire       = busy_r && (!out_valid_r || !out_stall);
  assign final_item = (count_r <= CNT_W'(1));

  assign ctrl.ins   = in_acc && (in_kind == KIND_INSERT) && !full;
  assign ctrl.drain = fire;

  // Cell chain: cell 0 holds the shortest job.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                prev_occ;
    logic                prev_gt;
    logic [KEY_BITS-1:0] prev_key;
    logic [TAG_BITS-1:0] prev_tag;
    logic [KEY_BITS-1:0] next_key;
    logic [TAG_BITS-1:0] next_tag;

    assign occ_w[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign prev_occ = 1'b1;
      assign prev_gt  = 1'b0;
      assign prev_key = new_key;
      assign prev_tag = in_job_tag;
    end else begin : g_body
      assign prev_occ = occ_w[i-1];
      assign prev_gt  = gt_w[i-1];
      assign prev_key = key_w[i-1];
      assign prev_tag = tag_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_key = key_w[i];
      assign next_tag = tag_w[i];
    end else begin : g_inner
      assign next_key = key_w[i+1];
      assign next_tag = tag_w[i+1];
    end

    sjfs_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_key  (new_key),
      .new_tag  (in_job_tag),
      .occ      (occ_w[i]),
      .prev_occ (prev_occ),
      .prev_gt  (prev_gt),
      .prev_key (prev_key),
      .prev_tag (prev_tag),
      .next_key (next_key),
      .next_tag (next_tag),
      .gt       (gt_w[i]),
      .key      (key_w[i]),
      .tag      (tag_w[i])
    );
  end

  // Control: insert, start a flush, drain one entry per free output slot.
  always_comb begin
    count_nxt = count_r;
    busy_nxt  = busy_r;
    ovf_nxt   = ovf_r;

    if (in_acc) begin
      if (in_kind == KIND_FLUSH) begin
        busy_nxt = 1'b1;
      end else if (full) begin
        ovf_nxt = 1'b1;  // drop the job, remember the loss
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (fire) begin
      if (final_item) begin
        count_nxt = '0;
        busy_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  // Output register: load on fire, hold while stalled.
  always_comb begin
    out_tag_nxt    = out_tag_r;
    out_length_nxt = out_length_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    out_ovf_nxt    = out_ovf_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (fire) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = final_item;
      out_ovf_nxt   = ovf_r;
      if (count_r == '0) begin
        out_tag_nxt    = '0;
        out_length_nxt = '0;
        out_empty_nxt  = 1'b1;
      end else begin
        out_tag_nxt    = tag_w[0];
        out_length_nxt = LEN_BITS'(key_w[0]);
        out_empty_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tag_r    <= out_tag_nxt;
    out_length_r <= out_length_nxt;
    out_last_r   <= out_last_nxt;
    out_empty_r  <= out_empty_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_tag        = out_tag_r;
  assign out_length     = out_length_r;
  assign out_last       = out_last_r;
  assign out_empty_res  = out_empty_r;
  assign out_overflowed = out_ovf_r;

  // Checks

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond store depth");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r)
    else $error("empty flush result not marked last");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    fire && final_item |=> !busy_r && count_r == '0 && !ovf_r)
    else $error("flush did not finish after final item");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_kind == KIND_INSERT && full |=> ovf_r && count_r == CNT_W'(DEPTH))
    else $error("insert into full store not dropped with overflow");

endmodule
